### sv/csem_pkg.sv
// Shared types, status codes and default sizes for the counting semaphore.
package csem_pkg;

	// Default sizes handed to the top-level parameters.
	localparam int QUEUE_DEPTH_DEF  = 16;
	localparam int TASK_ID_BITS_DEF = 8;

	// Width of the count and the maximum-count register.
	localparam int COUNT_W  = 8;
	localparam int STATUS_W = 3;

	// Reset value of the maximum count and of the free count.
	localparam logic [COUNT_W-1:0] MAX_COUNT_RST = COUNT_W'(1);

	// Operation codes on the cmd input.
	localparam logic CMD_ACQUIRE = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED  = 3'd0,
		ST_QUEUED   = 3'd1,
		ST_FULL     = 3'd2,
		ST_WOKEN    = 3'd3,
		ST_RETURNED = 3'd4
	} csem_status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // take the input transfer and read the queue head
		logic commit;    // update the state and load the result register
		logic cfg_load;  // load the maximum and free counts
	} csem_cmd_t;

endpackage

### sv/csem_ctrl.sv
// Controller state machine: sequences each operation and owns the handshakes.
module csem_ctrl
	import csem_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	output csem_cmd_t cmd_o
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   commit;

	// The result register is free when empty or when its transfer completes now.
	assign commit = (state_q == S_EXEC) && (!out_valid_q || !out_stall);

	// Handshake outputs and commands.
	assign in_stall         = (state_q != S_IDLE);
	assign cfg_ready        = (state_q == S_IDLE);
	assign out_valid        = out_valid_q;
	assign cmd_o.capture    = (state_q == S_IDLE) && in_valid;
	assign cmd_o.commit     = commit;
	assign cmd_o.cfg_load   = cfg_valid && (state_q == S_IDLE);

	// State and result-valid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### sv/csem_dp.sv
// Datapath: free count, wait queue memory with its pointers, and result register.
module csem_dp
	import csem_pkg::*;
#(
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int TASK_ID_BITS = TASK_ID_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  csem_cmd_t               cmd_i,
	input  logic                    cmd,
	input  logic [TASK_ID_BITS-1:0] task_id,
	input  logic [COUNT_W-1:0]      cfg_data,
	output logic [STATUS_W-1:0]     status,
	output logic [TASK_ID_BITS-1:0] woken_task,
	output logic [COUNT_W-1:0]      free_count
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [TASK_ID_BITS-1:0] wait_mem [QUEUE_DEPTH];

	logic                    cmd_q;
	logic [TASK_ID_BITS-1:0] id_q;
	logic [TASK_ID_BITS-1:0] head_data_q;
	logic [COUNT_W-1:0]      max_q;
	logic [COUNT_W-1:0]      free_q;
	logic [PTR_W-1:0]        head_q;
	logic [PTR_W-1:0]        tail_q;
	logic [CNT_W-1:0]        total_q;
	csem_status_t            status_q;
	logic [TASK_ID_BITS-1:0] woken_q;
	logic [COUNT_W-1:0]      free_out_q;

	logic                    do_grant;
	logic                    do_queue;
	logic                    do_wake;
	logic                    do_return;
	logic                    queue_full;
	logic                    queue_empty;
	logic [PTR_W-1:0]        head_next;
	logic [PTR_W-1:0]        tail_next;
	logic [COUNT_W-1:0]      free_next;
	csem_status_t            status_next;

	// Decode the operation from the captured command and current state.
	assign queue_full  = (total_q == CNT_W'(QUEUE_DEPTH));
	assign queue_empty = (total_q == '0);
	assign do_grant    = (cmd_q == CMD_ACQUIRE) && (free_q != '0);
	assign do_queue    = (cmd_q == CMD_ACQUIRE) && (free_q == '0) && !queue_full;
	assign do_wake     = (cmd_q == CMD_RELEASE) && !queue_empty;
	assign do_return   = (cmd_q == CMD_RELEASE) && queue_empty;

	// Pointers wrap from the last slot back to zero.
	assign head_next = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
	assign tail_next = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);

	// Next free count and status.
	always_comb begin
		free_next   = free_q;
		status_next = ST_FULL;
		if (do_grant) begin
			free_next   = free_q - COUNT_W'(1);
			status_next = ST_GRANTED;
		end else if (do_queue) begin
			status_next = ST_QUEUED;
		end else if (do_wake) begin
			status_next = ST_WOKEN;
		end else if (do_return) begin
			if (free_q < max_q) begin
				free_next = free_q + COUNT_W'(1);
			end
			status_next = ST_RETURNED;
		end
	end

	// Wait queue memory: written at the tail; the head is read at every input capture.
	always_ff @(posedge clk) begin
		if (cmd_i.commit && do_queue) begin
			wait_mem[tail_q] <= id_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.capture) begin
			head_data_q <= wait_mem[head_q];
			cmd_q       <= cmd;
			id_q        <= task_id;
		end
	end

	// Counts and pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= MAX_COUNT_RST;
			free_q  <= MAX_COUNT_RST;
			head_q  <= '0;
			tail_q  <= '0;
			total_q <= '0;
		end else if (cmd_i.cfg_load) begin
			max_q  <= cfg_data;
			free_q <= cfg_data;
		end else if (cmd_i.commit) begin
			free_q <= free_next;
			if (do_queue) begin
				tail_q  <= tail_next;
				total_q <= total_q + CNT_W'(1);
			end else if (do_wake) begin
				head_q  <= head_next;
				total_q <= total_q - CNT_W'(1);
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd_i.commit) begin
			status_q   <= status_next;
			woken_q    <= do_wake ? head_data_q : '0;
			free_out_q <= free_next;
		end
	end

	assign status     = status_q;
	assign woken_task = woken_q;
	assign free_count = free_out_q;

endmodule

### sv/counting_semaphore_with_wait_queue.sv
// An input transfer is captured, then committed to the result register once that
// register is free; the commit waits while an older result stays stalled.
// No new operation is taken until the current one is committed, as set by the
// controller's capture-then-commit sequence (the queue memory read is registered).
// The result register lets the next input transfer happen while a result waits.
// Asynchronous active-low reset: maximum and free count become 1, queue empty;
// queue memory contents are not cleared.
module counting_semaphore_with_wait_queue
	import csem_pkg::*;
#(
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int TASK_ID_BITS = TASK_ID_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    cmd,
	input  logic [TASK_ID_BITS-1:0] task_id,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [STATUS_W-1:0]     status,
	output logic [TASK_ID_BITS-1:0] woken_task,
	output logic [COUNT_W-1:0]      free_count,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [COUNT_W-1:0]      cfg_data
);

	csem_cmd_t dp_cmd;

	// Sequencing and handshakes.
	csem_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd_o     (dp_cmd)
	);

	// Counts, wait queue and result payload.
	csem_dp #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.TASK_ID_BITS (TASK_ID_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_i      (dp_cmd),
		.cmd        (cmd),
		.task_id    (task_id),
		.cfg_data   (cfg_data),
		.status     (status),
		.woken_task (woken_task),
		.free_count (free_count)
	);

endmodule

### test/counting_semaphore_with_wait_queue_tb.sv
// Self-checking testbench for the counting semaphore with its FIFO of waiting tasks.
module counting_semaphore_with_wait_queue_tb;
	import csem_pkg::*;

	localparam int WAIT_DEPTH = QUEUE_DEPTH_DEF;
	localparam int ID_W       = TASK_ID_BITS_DEF;
	localparam int IDLE_PCT   = 31;
	localparam int ITEM_GOAL  = 1600;
	localparam int CLK_HALF   = 2;
	localparam int RUN_LIMIT  = 4 * 200000;

	// One semaphore request and the answer the block should give to it.
	typedef struct {
		logic            op;
		logic [ID_W-1:0] id;
	} sem_req_t;

	typedef struct {
		csem_status_t       st;
		logic [ID_W-1:0]    woken;
		logic [COUNT_W-1:0] cnt;
	} sem_res_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                cmd;
	logic [ID_W-1:0]     task_id;
	logic                out_valid;
	logic                out_stall;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     woken_task;
	logic [COUNT_W-1:0]  free_count;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [COUNT_W-1:0]  cfg_data;

	// Predicted semaphore state.
	logic [COUNT_W-1:0] sem_max;
	logic [COUNT_W-1:0] sem_free;
	logic [ID_W-1:0]    sleepers[$];

	sem_req_t req_backlog[$];
	sem_res_t replies_due[$];
	bit       req_taken;
	bit       cfg_taken;
	bit       calm;
	int       faults;
	int       items_made;

	counting_semaphore_with_wait_queue dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.task_id    (task_id),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.woken_task (woken_task),
		.free_count (free_count),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Works out the answer to one request and advances the predicted state.
	function automatic sem_res_t predict_sem_op(logic op, logic [ID_W-1:0] id);
		sem_res_t r;
		r.woken = '0;
		if (op == CMD_ACQUIRE) begin
			if (sem_free != 0) begin
				sem_free = sem_free - 1'b1;
				r.st = ST_GRANTED;
			end else if (sleepers.size() >= WAIT_DEPTH) begin
				r.st = ST_FULL;
			end else begin
				sleepers.push_back(id);
				r.st = ST_QUEUED;
			end
		end else begin
			if (sleepers.size() > 0) begin
				r.woken = sleepers.pop_front();
				r.st = ST_WOKEN;
			end else begin
				// The count saturates at the configured maximum.
				if (sem_free < sem_max)
					sem_free = sem_free + 1'b1;
				r.st = ST_RETURNED;
			end
		end
		r.cnt = sem_free;
		return r;
	endfunction

	function void note_fault(string msg);
		faults++;
		if (faults <= 10)
			$display("mismatch: %s", msg);
	endfunction

	function void queue_req(logic op, logic [ID_W-1:0] id);
		req_backlog.push_back('{op: op, id: id});
		items_made++;
	endfunction

	// Monitor: checks each result transfer, then records configuration and
	// request transfers.
	always @(posedge clk) begin
		sem_res_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					note_fault($sformatf("unexpected result status=%0d woken=%0d free=%0d",
						status, woken_task, free_count));
				end else begin
					want = replies_due.pop_front();
					if (status !== want.st || woken_task !== want.woken ||
						free_count !== want.cnt) begin
						note_fault($sformatf(
							{"expected status=%0d woken=%0d free=%0d, ",
							"got status=%0d woken=%0d free=%0d"},
							want.st, want.woken, want.cnt, status, woken_task, free_count));
					end
				end
			end
			cfg_taken = cfg_valid && cfg_ready;
			if (cfg_taken) begin
				sem_max  = cfg_data;
				sem_free = cfg_data;
			end
			req_taken = in_valid && !in_stall;
			if (req_taken)
				replies_due.push_back(predict_sem_op(cmd, task_id));
		end
	end

	// Driver: presents backlog requests with random gaps and stalls the result side at random, unless calm.
	always @(negedge clk) begin
		sem_req_t nxt;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			out_stall <= 1'b0;
		end else begin
			if (!in_valid || req_taken) begin
				if (req_backlog.size() == 0 || (!calm && $urandom_range(99) < IDLE_PCT)) begin
					in_valid <= 1'b0;
				end else begin
					nxt = req_backlog.pop_front();
					in_valid <= 1'b1;
					cmd      <= nxt.op;
					task_id  <= nxt.id;
				end
			end
			out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Waits until every request has been sent and every answer has come back.
	// The check runs a little after the falling edge, once the driver has settled.
	task automatic wait_settled();
		do begin
			@(negedge clk);
			#1;
		end while (req_backlog.size() != 0 || in_valid || replies_due.size() != 0);
	endtask

	task automatic write_max(int val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= COUNT_W'(val);
		do
			@(negedge clk);
		while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	// Stimulus: a directed opening, then phases of random traffic under varied maxima.
	initial begin
		int val;
		int bias;
		int seg;
		int n;
		int phase;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		cmd        = CMD_ACQUIRE;
		task_id    = '0;
		out_stall  = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		calm       = 1'b0;
		faults     = 0;
		items_made = 0;
		req_taken  = 1'b0;
		cfg_taken  = 1'b0;
		sem_max    = MAX_COUNT_RST;
		sem_free   = MAX_COUNT_RST;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Grant, return, return at the maximum, grant, then two waiters queued and woken in order, then a return.
		queue_req(CMD_ACQUIRE, 8'h00);
		queue_req(CMD_RELEASE, 8'h00);
		queue_req(CMD_RELEASE, 8'hFF);
		queue_req(CMD_ACQUIRE, 8'hFF);
		queue_req(CMD_ACQUIRE, 8'hFF);
		queue_req(CMD_ACQUIRE, 8'h00);
		queue_req(CMD_RELEASE, 8'h5A);
		queue_req(CMD_RELEASE, 8'hA5);
		queue_req(CMD_RELEASE, 8'h00);
		wait_settled();

		// With no free units the queue fills and the next caller is turned away.
		write_max(0);
		for (int k = 0; k <= WAIT_DEPTH; k++)
			queue_req(CMD_ACQUIRE, ID_W'(k * 15));
		wait_settled();

		// Random phases; the first three use the extreme and smallest maxima.
		phase = 0;
		while (items_made < ITEM_GOAL) begin
			case (phase)
				0: val = 255;
				1: val = 0;
				2: val = 1;
				default: begin
					case ($urandom_range(0, 3))
						0, 1: val = $urandom_range(0, 4);
						2: val = $urandom_range(0, 255);
						default: val = 255;
					endcase
				end
			endcase
			calm = (phase == 3);
			write_max(val);
			n = $urandom_range(80, 200);
			while (n > 0) begin
				seg = $urandom_range(1, 24);
				case ($urandom_range(0, 2))
					0: bias = 80;
					1: bias = 20;
					default: bias = 50;
				endcase
				for (int k = 0; k < seg; k++)
					queue_req(($urandom_range(99) < bias) ? CMD_ACQUIRE : CMD_RELEASE,
						ID_W'($urandom_range(0, 255)));
				n -= seg;
			end
			wait_settled();
			phase++;
		end
		calm = 1'b0;

		repeat (8) @(negedge clk);
		if (faults == 0 && replies_due.size() == 0)
			$display("counting_semaphore_with_wait_queue_tb OK");
		else
			$display("counting_semaphore_with_wait_queue_tb NOT OK");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#RUN_LIMIT;
		$display("counting_semaphore_with_wait_queue_tb NOT OK");
		$finish;
	end

endmodule

### files.f
sv/csem_pkg.sv
sv/csem_ctrl.sv
sv/csem_dp.sv
sv/counting_semaphore_with_wait_queue.sv
test/counting_semaphore_with_wait_queue_tb.sv
